// ===== design/afcs_pkg.sv =====
package afcs_pkg;

   localparam int unsigned VolW = 16;
   localparam int unsigned IdW = 16;
   localparam int unsigned TickW = 16;
   localparam int unsigned ElapsedW = 17;
   localparam logic [VolW-1:0] FullScale = 16'd32768;
   localparam logic [ElapsedW-1:0] ElapsedMax = 17'h1FFFF;

   // opcodes of the request transaction
   localparam logic [2:0] OpTick = 3'd0;
   localparam logic [2:0] OpPlay = 3'd1;
   localparam logic [2:0] OpStop = 3'd2;
   localparam logic [2:0] OpSwitch = 3'd3;
   localparam logic [2:0] OpCross = 3'd4;

   // sequencer modes
   localparam logic [2:0] ModeIdle = 3'd0;
   localparam logic [2:0] ModePlaying = 3'd1;
   localparam logic [2:0] ModeFadeIn = 3'd2;
   localparam logic [2:0] ModeFadeOut = 3'd3;
   localparam logic [2:0] ModeSwitchOut = 3'd4;
   localparam logic [2:0] ModeCross = 3'd5;

   typedef struct packed {
      logic [2:0] opcode;
      logic [IdW-1:0] track_id;
      logic loop_flag;
      logic [VolW-1:0] target_volume;
      logic [TickW-1:0] fade_in_ticks;
      logic [TickW-1:0] fade_out_ticks;
      logic [TickW-1:0] delta_ticks;
   } req_type;

   typedef struct packed {
      logic [2:0] mode;
      logic main_active;
      logic [IdW-1:0] main_track;
      logic main_loop;
      logic [VolW-1:0] main_level;
      logic main_started;
      logic aux_active;
      logic [IdW-1:0] aux_track;
      logic [VolW-1:0] aux_level;
      logic aux_stopped;
   } rsp_type;

   // scale request to the divide unit: target * num / den
   typedef struct packed {
      logic start;
      logic [VolW-1:0] target;
      logic [TickW-1:0] num;
      logic [TickW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [VolW-1:0] quot;
   } div_rsp_type;

endpackage

// ===== design/afcs_if.sv =====
interface afcs_req_if;
   import afcs_pkg::*;
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface afcs_rsp_if;
   import afcs_pkg::*;
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/audio_fade_crossfade_sequencer.sv =====
// Fade and crossfade sequencer for a main and an auxiliary playback channel.
// req channel: one transaction per command (tick, play, stop, switch,
// crossfade); rsp channel: exactly one transaction per request, giving the
// channel state after the command, with start and stop pulses.
// Commands that need no ramp level skip the divider and answer directly. A tick
// in a running ramp drives the shared 32-step restoring divider once for the
// main level and once more for the auxiliary level in a crossfade before the
// response is set. One request is handled at a time; req_ready is low from
// acceptance until the response is taken.
// The response sits in an output register; while the receiver stalls it is
// held and no new request is accepted.
// Reset (synchronous, active high) idles both channels: ids 0, targets full
// scale, loop set, levels 0, mode idle, response register empty.
module audio_fade_crossfade_sequencer (
   input logic clock,
   input logic reset,
   afcs_req_if.sink req,
   afcs_rsp_if.source rsp
);
   import afcs_pkg::*;

   typedef enum logic [4:0] {
      StIdle = 5'b00001,
      StMain = 5'b00010,
      StAux = 5'b00100,
      StWait = 5'b01000,
      StOut = 5'b10000
   } state_type;

   state_type st_ff, st_in;

   logic [2:0] mode_ff, mode_in;
   logic mv_ff, mv_in, ml_ff, ml_in, av_ff, av_in, al_ff, al_in;
   logic [IdW-1:0] mid_ff, mid_in, aid_ff, aid_in;
   logic [VolW-1:0] mt_ff, mt_in, mlev_ff, mlev_in, at_ff, at_in, alev_ff, alev_in;
   logic [TickW-1:0] fin_ff, fin_in, fout_ff, fout_in, cl_ff, cl_in;
   logic [ElapsedW-1:0] el_ff, el_in;
   logic ps_ff, ps_in, pst_ff, pst_in;
   logic needm_ff, needm_in, needa_ff, needa_in;
   logic [TickW-1:0] mnum_ff, mnum_in, mden_ff, mden_in, anum_ff, anum_in;
   logic rv_ff, rv_in;
   div_req_type dreq;
   div_rsp_type drsp;

   afcs_scale_div u_div (.clock(clock), .reset(reset), .div_req(dreq), .div_rsp(drsp));

   // command evaluation: mirrors the sequencer rules, divisions are deferred
   always_comb begin
      logic [2:0] op;
      logic lp;
      logic [IdW-1:0] id;
      logic [VolW-1:0] vol;
      logic [TickW-1:0] fin, fout, len;
      logic [ElapsedW:0] sum;
      logic mm, mp, do_play, clr_all;
      logic [IdW-1:0] pid;
      logic [VolW-1:0] pvol;
      logic plp;
      logic [TickW-1:0] pfin;

      op = req.payload.opcode;
      id = req.payload.track_id;
      lp = req.payload.loop_flag;
      vol = (req.payload.target_volume > FullScale) ? FullScale : req.payload.target_volume;
      fin = req.payload.fade_in_ticks;
      fout = req.payload.fade_out_ticks;
      sum = '0;
      len = '0;
      do_play = 1'b0;
      clr_all = 1'b0;
      pid = id;
      pvol = vol;
      plp = lp;
      pfin = fin;

      mode_in = mode_ff; mv_in = mv_ff; ml_in = ml_ff; av_in = av_ff; al_in = al_ff;
      mid_in = mid_ff; aid_in = aid_ff; mt_in = mt_ff; at_in = at_ff;
      mlev_in = mlev_ff; alev_in = alev_ff;
      fin_in = fin_ff; fout_in = fout_ff; cl_in = cl_ff; el_in = el_ff;
      ps_in = ps_ff; pst_in = pst_ff;
      needm_in = 1'b0; needa_in = 1'b0;
      mnum_in = mnum_ff; mden_in = mden_ff; anum_in = anum_ff;

      mm = (mode_ff != ModeSwitchOut) && mv_ff && (mid_ff == id) && (mt_ff == vol)
         && (ml_ff == lp);
      mp = (mode_ff == ModeSwitchOut) && (aid_ff == id) && (at_ff == vol) && (al_ff == lp);

      if (st_ff == StIdle && req.valid) begin
         ps_in = 1'b0;
         pst_in = 1'b0;
         case (op)
            OpTick: begin
               if (mode_ff >= ModeFadeIn && mode_ff <= ModeCross) begin
                  sum = {1'b0, el_ff} + (ElapsedW + 1)'(req.payload.delta_ticks);
                  el_in = sum[ElapsedW] ? ElapsedMax : sum[ElapsedW-1:0];
                  case (mode_ff)
                     ModeFadeIn: begin
                        if (el_in > {1'b0, fin_ff}) begin
                           mlev_in = mt_ff; mode_in = ModePlaying;
                        end else begin
                           needm_in = 1'b1; mnum_in = el_in[TickW-1:0]; mden_in = fin_ff;
                        end
                     end
                     ModeFadeOut, ModeSwitchOut: begin
                        if (el_in > {1'b0, fout_ff}) begin
                           clr_all = 1'b1;
                           if (mode_ff == ModeSwitchOut) begin
                              do_play = 1'b1;
                              pid = aid_ff; pvol = at_ff; plp = al_ff; pfin = fin_ff;
                           end
                        end else begin
                           needm_in = 1'b1;
                           mnum_in = fout_ff - el_in[TickW-1:0];
                           mden_in = fout_ff;
                        end
                     end
                     default: begin
                        if (el_in > {1'b0, cl_ff}) begin
                           mlev_in = mt_ff; mode_in = ModePlaying;
                           if (av_ff) begin
                              av_in = 1'b0; aid_in = '0; at_in = FullScale;
                              al_in = 1'b1; alev_in = '0; pst_in = 1'b1;
                           end
                        end else begin
                           needm_in = 1'b1; mnum_in = el_in[TickW-1:0]; mden_in = cl_ff;
                           needa_in = av_ff; anum_in = cl_ff - el_in[TickW-1:0];
                        end
                     end
                  endcase
               end
            end
            OpPlay: do_play = 1'b1;
            OpStop: begin
               if (!(mode_ff == ModeIdle && !mv_ff && !av_ff)) begin
                  if (fout == '0) clr_all = 1'b1;
                  else if (mode_ff != ModeFadeOut) begin
                     mode_in = ModeFadeOut; fout_in = fout; el_in = '0;
                  end
               end
            end
            OpSwitch: begin
               if (!(mm || mp)) begin
                  if (fout == '0 || !mv_ff) do_play = 1'b1;
                  else begin
                     if (av_ff) begin
                        av_in = 1'b0; alev_in = '0; pst_in = 1'b1;
                     end
                     aid_in = id; at_in = vol; al_in = lp;
                     mode_in = ModeSwitchOut; fout_in = fout; fin_in = fin; el_in = '0;
                  end
               end
            end
            OpCross: begin
               if (!(mm || mp)) begin
                  if (!mv_ff || fin == '0) do_play = 1'b1;
                  else begin
                     if (av_ff) pst_in = 1'b1;
                     av_in = 1'b1; aid_in = mid_ff; at_in = mt_ff; al_in = ml_ff;
                     alev_in = mlev_ff;
                     mv_in = 1'b1; mid_in = id; mt_in = vol; ml_in = lp; mlev_in = '0;
                     ps_in = 1'b1;
                     mode_in = ModeCross; cl_in = fin; el_in = '0;
                  end
               end
            end
            default: ;
         endcase

         // immediate stop of both channels
         if (clr_all) begin
            if (mv_ff) begin
               mv_in = 1'b0; mid_in = '0; mt_in = FullScale; ml_in = 1'b1; mlev_in = '0;
            end
            if (av_ff) begin
               av_in = 1'b0; aid_in = '0; at_in = FullScale; al_in = 1'b1; alev_in = '0;
               pst_in = 1'b1;
            end
            mode_in = ModeIdle;
         end

         // play: direct requests are checked against the state before this
         // transaction; the switch completion plays on a cleared main
         if (do_play) begin
            len = pfin;
            if (op != OpTick && mm) begin
               if (mode_ff == ModeFadeOut) mode_in = ModePlaying;
            end else if (op != OpTick && mp) begin
               mode_in = mode_ff;
            end else begin
               if (op != OpTick) begin
                  if (mv_ff) begin
                     mid_in = '0; mt_in = FullScale; ml_in = 1'b1;
                  end
                  if (av_ff) begin
                     av_in = 1'b0; aid_in = '0; at_in = FullScale; al_in = 1'b1;
                     alev_in = '0; pst_in = 1'b1;
                  end
               end
               mv_in = 1'b1; mid_in = pid; mt_in = pvol; ml_in = plp; ps_in = 1'b1;
               if (len == '0) begin
                  mlev_in = pvol; mode_in = ModePlaying;
               end else begin
                  mlev_in = '0; mode_in = ModeFadeIn; fin_in = len; el_in = '0;
               end
            end
         end
      end
   end

   // sequencer: evaluate, then run the shared divider for main and aux levels
   always_comb begin
      st_in = st_ff;
      rv_in = rv_ff;
      dreq.start = 1'b0;
      dreq.target = mt_ff;
      dreq.num = mnum_ff;
      dreq.den = mden_ff;
      case (st_ff)
         StIdle: if (req.valid) st_in = StMain;
         StMain: begin
            if (needm_ff) begin
               dreq.start = 1'b1; st_in = StWait;
            end else if (needa_ff) begin
               dreq.start = 1'b1; dreq.target = at_ff; dreq.num = anum_ff;
               st_in = StAux;
            end else begin
               rv_in = 1'b1; st_in = StOut;
            end
         end
         StWait, StAux: if (drsp.done) st_in = StMain;
         StOut: if (rsp.ready) begin
            rv_in = 1'b0; st_in = StIdle;
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle;
         rv_ff <= 1'b0;
         mode_ff <= ModeIdle;
         mv_ff <= 1'b0; mid_ff <= '0; mt_ff <= FullScale; ml_ff <= 1'b1; mlev_ff <= '0;
         av_ff <= 1'b0; aid_ff <= '0; at_ff <= FullScale; al_ff <= 1'b1; alev_ff <= '0;
         fin_ff <= '0; fout_ff <= '0; cl_ff <= '0; el_ff <= '0;
         ps_ff <= 1'b0; pst_ff <= 1'b0;
         needm_ff <= 1'b0; needa_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         if (st_ff == StIdle) begin
            mode_ff <= mode_in;
            mv_ff <= mv_in; mid_ff <= mid_in; mt_ff <= mt_in; ml_ff <= ml_in;
            av_ff <= av_in; aid_ff <= aid_in; at_ff <= at_in; al_ff <= al_in;
            fin_ff <= fin_in; fout_ff <= fout_in; cl_ff <= cl_in; el_ff <= el_in;
            ps_ff <= ps_in; pst_ff <= pst_in;
            mlev_ff <= mlev_in; alev_ff <= alev_in;
            needm_ff <= needm_in; needa_ff <= needa_in;
         end else if (drsp.done && st_ff == StWait) begin
            mlev_ff <= drsp.quot; needm_ff <= 1'b0;
         end else if (drsp.done && st_ff == StAux) begin
            alev_ff <= drsp.quot; needa_ff <= 1'b0;
         end
      end
      if (st_ff == StIdle) begin
         mnum_ff <= mnum_in; mden_ff <= mden_in; anum_ff <= anum_in;
      end
   end

   assign req.ready = (st_ff == StIdle);
   assign rsp.valid = rv_ff;
   assign rsp.payload.mode = mode_ff;
   assign rsp.payload.main_active = mv_ff;
   assign rsp.payload.main_track = mid_ff;
   assign rsp.payload.main_loop = ml_ff;
   assign rsp.payload.main_level = mlev_ff;
   assign rsp.payload.main_started = ps_ff;
   assign rsp.payload.aux_active = av_ff;
   assign rsp.payload.aux_track = aid_ff;
   assign rsp.payload.aux_level = alev_ff;
   assign rsp.payload.aux_stopped = pst_ff;

endmodule

// ===== design/afcs_scale_div.sv =====
module afcs_scale_div (
   input logic clock,
   input logic reset,
   input afcs_pkg::div_req_type div_req,
   output afcs_pkg::div_rsp_type div_rsp
);
   import afcs_pkg::*;

   localparam int unsigned ProdW = VolW + TickW;
   localparam int unsigned CntW = $clog2(ProdW + 1);

   logic busy_ff, busy_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [ProdW-1:0] prod_ff, prod_in;
   logic [TickW-1:0] rem_ff, rem_in;
   logic [TickW-1:0] den_ff, den_in;
   logic done_ff, done_in;
   logic [TickW:0] trial;

   // one restoring step a cycle, quotient bits shift into the product register
   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      done_in = 1'b0;
      trial = {rem_ff, prod_ff[ProdW-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = CntW'(ProdW);
         prod_in = div_req.target * div_req.num;
         rem_in = '0;
         den_in = div_req.den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial[TickW-1:0] - den_ff;
            prod_in = {prod_ff[ProdW-2:0], 1'b1};
         end else begin
            rem_in = trial[TickW-1:0];
            prod_in = {prod_ff[ProdW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // zero length gives zero; quotient never exceeds target so it fits
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = (den_ff == '0) ? '0 : prod_ff[VolW-1:0];

endmodule
